// ===== rtl/core/orot_pkg.sv =====
// Shared types and constants for the oriented rectangle overlap test.
// Used by the sine/cosine pipeline, the axis lanes, the coarse test and the top level.
package orot_pkg;

    localparam int COORD_W     = 24;
    localparam int LEN_W       = 20;
    localparam int ANGLE_BITS  = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int TRIG_W      = 18;
    localparam int TRIG_FRAC   = 16;
    localparam int TRIG_ONE    = 65536;

    localparam int CORDIC_STEPS    = 30;
    localparam int CORDIC_GAIN     = 652032875;
    localparam int ROUND_SHIFT     = 14;
    localparam int ROUND_BIAS      = 8192;
    localparam int STEPS_PER_STAGE = 2;
    localparam int ITER_STAGES     = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int TRIG_STAGES     = ITER_STAGES + 1;
    localparam int LANE_STAGES     = 5;
    localparam int COARSE_STAGES   = 3;
    localparam int PIPE_STAGES     = TRIG_STAGES + LANE_STAGES + 1;
    localparam int NUM_AXES        = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic        [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef struct packed {
        coord_t a_center_x;
        coord_t a_center_y;
        len_t   a_half_width;
        len_t   a_half_height;
        angle_t a_angle;
        coord_t b_center_x;
        coord_t b_center_y;
        len_t   b_half_width;
        len_t   b_half_height;
        angle_t b_angle;
    } pair_t;

    typedef struct packed {
        logic overlap;
        logic coarse_overlap;
    } result_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/orot_cordic.sv =====
// Pipelined rotation-mode CORDIC: angle (fraction of a turn) to cosine and sine,
// 16 fraction bits, clamped to +-1. Depends on orot_pkg.
module orot_cordic
    import orot_pkg::*;
(
    input  logic                   clk,
    input  logic [TRIG_STAGES-1:0] en,
    input  angle_t                 angle,
    output trig_t                  cos_v,
    output trig_t                  sin_v
);

    localparam int XW = 33;
    localparam int ZW = 32;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cstate_t;

    function automatic cstate_t rot(input cstate_t s, input int unsigned i);
        cstate_t r;
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        sx = s.x;
        sy = s.y;
        dx = sy >>> i;
        dy = sx >>> i;
        at = ZW'(atan_turn(i));
        if (!s.z[ZW-1])
        begin
            r.x = sx - dx;
            r.y = sy + dy;
            r.z = s.z - at;
        end
        else
        begin
            r.x = sx + dx;
            r.y = sy - dy;
            r.z = s.z + at;
        end
        return r;
    endfunction

    function automatic trig_t round_clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        trig_t r;
        t = (v + XW'(ROUND_BIAS)) >>> ROUND_SHIFT;
        if (t > XW'(TRIG_ONE))
            r = TRIG_W'(TRIG_ONE);
        else if (t < -XW'(TRIG_ONE))
            r = -TRIG_W'(TRIG_ONE);
        else
            r = TRIG_W'(t);
        return r;
    endfunction

    logic [31:0] turn;
    cstate_t     init_s;
    cstate_t     st_reg [ITER_STAGES];
    logic [1:0]  quad_reg [ITER_STAGES];
    trig_t       cos_reg;
    trig_t       sin_reg;
    trig_t       c_r;
    trig_t       s_r;
    trig_t       cos_next;
    trig_t       sin_next;

    assign turn = {angle, {(32 - ANGLE_BITS){1'b0}}};

    always_comb
    begin
        init_s.x = XW'(CORDIC_GAIN);
        init_s.y = '0;
        init_s.z = ZW'(turn[29:0]);
    end

    for (genvar j = 0; j < ITER_STAGES; j++)
    begin : g_iter
        cstate_t    s_in;
        logic [1:0] q_in;
        if (j == 0)
        begin : g_first
            assign s_in = init_s;
            assign q_in = turn[31:30];
        end
        else
        begin : g_rest
            assign s_in = st_reg[j-1];
            assign q_in = quad_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                st_reg[j]   <= rot(rot(s_in, STEPS_PER_STAGE * j),
                                   STEPS_PER_STAGE * j + 1);
                quad_reg[j] <= q_in;
            end
        end
    end

    assign c_r = round_clamp(st_reg[ITER_STAGES-1].x);
    assign s_r = round_clamp(st_reg[ITER_STAGES-1].y);

    // quadrant restored by exact negation and swap
    always_comb
    begin
        case (quad_reg[ITER_STAGES-1])
            2'd0:
            begin
                cos_next = c_r;
                sin_next = s_r;
            end
            2'd1:
            begin
                cos_next = -s_r;
                sin_next = c_r;
            end
            2'd2:
            begin
                cos_next = -c_r;
                sin_next = -s_r;
            end
            default:
            begin
                cos_next = s_r;
                sin_next = -c_r;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[TRIG_STAGES-1])
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_v = cos_reg;
    assign sin_v = sin_reg;

endmodule

// ===== rtl/core/orot_axis_lane.sv =====
// One separating-axis lane: projects both boxes on axis (ux,uy) and flags a gap.
// Five register stages. Depends on orot_pkg.
module orot_axis_lane
    import orot_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  trig_t                  a_cos,
    input  trig_t                  a_sin,
    input  trig_t                  b_cos,
    input  trig_t                  b_sin,
    input  trig_t                  ux,
    input  trig_t                  uy,
    input  diff_t                  dx,
    input  diff_t                  dy,
    input  len_t                   a_w,
    input  len_t                   a_h,
    input  len_t                   b_w,
    input  len_t                   b_h,
    output logic                   sep
);

    localparam int PW = 2 * TRIG_W;
    localparam int SW = PW + 1;
    localparam int MW = 34;
    localparam int DPW = DIFF_W + TRIG_W;
    localparam int DSW = DPW + 1;
    localparam int DMW = DPW;
    localparam int RW = MW + LEN_W;
    localparam int RSW = RW + 2;
    localparam int CW = DMW + TRIG_FRAC;

    // stage 1: products
    logic signed [PW-1:0]  acux_reg, asuy_reg, acuy_reg, asux_reg;
    logic signed [PW-1:0]  bcux_reg, bsuy_reg, bcuy_reg, bsux_reg;
    logic signed [DPW-1:0] pdx_reg, pdy_reg;
    len_t aw1_reg, ah1_reg, bw1_reg, bh1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            acux_reg <= a_cos * ux;
            asuy_reg <= a_sin * uy;
            acuy_reg <= a_cos * uy;
            asux_reg <= a_sin * ux;
            bcux_reg <= b_cos * ux;
            bsuy_reg <= b_sin * uy;
            bcuy_reg <= b_cos * uy;
            bsux_reg <= b_sin * ux;
            pdx_reg  <= dx * ux;
            pdy_reg  <= dy * uy;
            aw1_reg  <= a_w;
            ah1_reg  <= a_h;
            bw1_reg  <= b_w;
            bh1_reg  <= b_h;
        end
    end

    // stage 2: dot products and magnitudes
    logic signed [SW-1:0]  ta, ua, tb, ub;
    logic signed [DSW-1:0] dsum;
    logic signed [SW-1:0]  ta_a, ua_a, tb_a, ub_a;
    logic signed [DSW-1:0] d_a;
    logic [MW-1:0]  tam_reg, uam_reg, tbm_reg, ubm_reg;
    logic [DMW-1:0] dm2_reg;
    len_t aw2_reg, ah2_reg, bw2_reg, bh2_reg;

    assign ta   = SW'(acux_reg) + SW'(asuy_reg);
    assign ua   = SW'(acuy_reg) - SW'(asux_reg);
    assign tb   = SW'(bcux_reg) + SW'(bsuy_reg);
    assign ub   = SW'(bcuy_reg) - SW'(bsux_reg);
    assign dsum = DSW'(pdx_reg) + DSW'(pdy_reg);
    assign ta_a = ta[SW-1] ? -ta : ta;
    assign ua_a = ua[SW-1] ? -ua : ua;
    assign tb_a = tb[SW-1] ? -tb : tb;
    assign ub_a = ub[SW-1] ? -ub : ub;
    assign d_a  = dsum[DSW-1] ? -dsum : dsum;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tam_reg <= ta_a[MW-1:0];
            uam_reg <= ua_a[MW-1:0];
            tbm_reg <= tb_a[MW-1:0];
            ubm_reg <= ub_a[MW-1:0];
            dm2_reg <= d_a[DMW-1:0];
            aw2_reg <= aw1_reg;
            ah2_reg <= ah1_reg;
            bw2_reg <= bw1_reg;
            bh2_reg <= bh1_reg;
        end
    end

    // stage 3: scale by half extents
    logic [RW-1:0]  m1_reg, m2_reg, m3_reg, m4_reg;
    logic [DMW-1:0] dm3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            m1_reg  <= tam_reg * aw2_reg;
            m2_reg  <= uam_reg * ah2_reg;
            m3_reg  <= tbm_reg * bw2_reg;
            m4_reg  <= ubm_reg * bh2_reg;
            dm3_reg <= dm2_reg;
        end
    end

    // stage 4: combined radius
    logic [RSW-1:0] rad_reg;
    logic [DMW-1:0] dm4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rad_reg <= RSW'(m1_reg) + RSW'(m2_reg) + RSW'(m3_reg) + RSW'(m4_reg);
            dm4_reg <= dm3_reg;
        end
    end

    // stage 5: gap when center distance reaches the radius sum
    logic sep_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
            sep_reg <= {dm4_reg, {TRIG_FRAC{1'b0}}} >= CW'(rad_reg);
    end

    assign sep = sep_reg;

endmodule

// ===== rtl/core/orot_coarse.sv =====
// Coarse test on axis-aligned extents of both rotated boxes; touching overlaps.
// Three register stages. Depends on orot_pkg.
module orot_coarse
    import orot_pkg::*;
(
    input  logic                     clk,
    input  logic [COARSE_STAGES-1:0] en,
    input  trig_t                    a_cos,
    input  trig_t                    a_sin,
    input  trig_t                    b_cos,
    input  trig_t                    b_sin,
    input  diff_t                    dx,
    input  diff_t                    dy,
    input  len_t                     a_w,
    input  len_t                     a_h,
    input  len_t                     b_w,
    input  len_t                     b_h,
    output logic                     coarse
);

    localparam int AW = TRIG_W - 1;
    localparam int PW = AW + LEN_W;
    localparam int EW = PW + 2;
    localparam int CW = DIFF_W + TRIG_FRAC;

    function automatic logic [AW-1:0] mag_trig(input trig_t v);
        trig_t t;
        t = v[TRIG_W-1] ? -v : v;
        return t[AW-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] mag_diff(input diff_t v);
        return v[DIFF_W-1] ? -v : v;
    endfunction

    logic [PW-1:0] acw_reg, ash_reg, asw_reg, ach_reg;
    logic [PW-1:0] bcw_reg, bsh_reg, bsw_reg, bch_reg;
    logic [DIFF_W-1:0] dxm1_reg, dym1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            acw_reg  <= mag_trig(a_cos) * a_w;
            ash_reg  <= mag_trig(a_sin) * a_h;
            asw_reg  <= mag_trig(a_sin) * a_w;
            ach_reg  <= mag_trig(a_cos) * a_h;
            bcw_reg  <= mag_trig(b_cos) * b_w;
            bsh_reg  <= mag_trig(b_sin) * b_h;
            bsw_reg  <= mag_trig(b_sin) * b_w;
            bch_reg  <= mag_trig(b_cos) * b_h;
            dxm1_reg <= mag_diff(dx);
            dym1_reg <= mag_diff(dy);
        end
    end

    logic [EW-1:0] ex_reg, ey_reg;
    logic [DIFF_W-1:0] dxm2_reg, dym2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ex_reg   <= EW'(acw_reg) + EW'(ash_reg) + EW'(bcw_reg) + EW'(bsh_reg);
            ey_reg   <= EW'(asw_reg) + EW'(ach_reg) + EW'(bsw_reg) + EW'(bch_reg);
            dxm2_reg <= dxm1_reg;
            dym2_reg <= dym1_reg;
        end
    end

    logic coarse_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
            coarse_reg <= !(({dxm2_reg, {TRIG_FRAC{1'b0}}} > CW'(ex_reg)) ||
                            ({dym2_reg, {TRIG_FRAC{1'b0}}} > CW'(ey_reg)));
    end

    assign coarse = coarse_reg;

endmodule

// ===== rtl/core/oriented_rect_overlap_test_top.sv =====
// Oriented rectangle overlap test, top level: pipeline control, geometry delay
// line and final combine. Depends on orot_pkg, orot_cordic, orot_axis_lane, orot_coarse.
//
// Accepts one rectangle pair per clock when nothing stalls and returns one result
// per pair, in order. The depth is set by the 30-step CORDIC (two steps per
// stage, plus a rounding stage), followed by five stages of projection arithmetic
// per separating axis. Every stage holds its own valid bit, so empty stages fill
// while the output is stalled.
module oriented_rect_overlap_test_top
    import orot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_stall,
    input  pair_t   pair,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef struct packed {
        diff_t dx;
        diff_t dy;
        len_t  a_w;
        len_t  a_h;
        len_t  b_w;
        len_t  b_h;
        logic  zero;
    } geo_t;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   rdy;

    always_comb
    begin
        rdy[PIPE_STAGES] = !result_stall;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
            rdy[i] = !valid_reg[i] || rdy[i+1];
    end

    assign valid_next = {valid_reg[PIPE_STAGES-2:0], pair_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
                if (rdy[i])
                    valid_reg[i] <= valid_next[i];
        end
    end

    assign pair_stall   = !rdy[0];
    assign result_valid = valid_reg[PIPE_STAGES-1];

    // geometry rides alongside the trig pipeline
    geo_t geo_in;
    geo_t geo_reg [TRIG_STAGES];

    always_comb
    begin
        geo_in.dx   = DIFF_W'(pair.a_center_x) - DIFF_W'(pair.b_center_x);
        geo_in.dy   = DIFF_W'(pair.a_center_y) - DIFF_W'(pair.b_center_y);
        geo_in.a_w  = pair.a_half_width;
        geo_in.a_h  = pair.a_half_height;
        geo_in.b_w  = pair.b_half_width;
        geo_in.b_h  = pair.b_half_height;
        geo_in.zero = (pair.a_angle == '0) && (pair.b_angle == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TRIG_STAGES; i++)
            if (rdy[i])
                geo_reg[i] <= (i == 0) ? geo_in : geo_reg[(i == 0) ? 0 : i - 1];
    end

    trig_t a_cos, a_sin, b_cos, b_sin;

    orot_cordic u_cordic_a (
        .clk   (clk),
        .en    (rdy[TRIG_STAGES-1:0]),
        .angle (pair.a_angle),
        .cos_v (a_cos),
        .sin_v (a_sin)
    );

    orot_cordic u_cordic_b (
        .clk   (clk),
        .en    (rdy[TRIG_STAGES-1:0]),
        .angle (pair.b_angle),
        .cos_v (b_cos),
        .sin_v (b_sin)
    );

    geo_t geo;
    assign geo = geo_reg[TRIG_STAGES-1];

    trig_t ux [NUM_AXES];
    trig_t uy [NUM_AXES];
    logic [NUM_AXES-1:0] sep;

    always_comb
    begin
        ux[0] = a_cos;
        uy[0] = a_sin;
        ux[1] = -a_sin;
        uy[1] = a_cos;
        ux[2] = b_cos;
        uy[2] = b_sin;
        ux[3] = -b_sin;
        uy[3] = b_cos;
    end

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_axis
        orot_axis_lane u_lane (
            .clk   (clk),
            .en    (rdy[TRIG_STAGES +: LANE_STAGES]),
            .a_cos (a_cos),
            .a_sin (a_sin),
            .b_cos (b_cos),
            .b_sin (b_sin),
            .ux    (ux[k]),
            .uy    (uy[k]),
            .dx    (geo.dx),
            .dy    (geo.dy),
            .a_w   (geo.a_w),
            .a_h   (geo.a_h),
            .b_w   (geo.b_w),
            .b_h   (geo.b_h),
            .sep   (sep[k])
        );
    end

    logic coarse;

    orot_coarse u_coarse (
        .clk    (clk),
        .en     (rdy[TRIG_STAGES +: COARSE_STAGES]),
        .a_cos  (a_cos),
        .a_sin  (a_sin),
        .b_cos  (b_cos),
        .b_sin  (b_sin),
        .dx     (geo.dx),
        .dy     (geo.dy),
        .a_w    (geo.a_w),
        .a_h    (geo.a_h),
        .b_w    (geo.b_w),
        .b_h    (geo.b_h),
        .coarse (coarse)
    );

    localparam int CDLY = LANE_STAGES - COARSE_STAGES;
    localparam int CBASE = TRIG_STAGES + COARSE_STAGES;

    logic [LANE_STAGES-1:0] zero_reg;
    logic [CDLY-1:0]        coarse_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANE_STAGES; i++)
            if (rdy[TRIG_STAGES + i])
                zero_reg[i] <= (i == 0) ? geo.zero : zero_reg[(i == 0) ? 0 : i - 1];
        for (int i = 0; i < CDLY; i++)
            if (rdy[CBASE + i])
                coarse_reg[i] <= (i == 0) ? coarse : coarse_reg[(i == 0) ? 0 : i - 1];
    end

    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[PIPE_STAGES-1])
        begin
            result_reg.coarse_overlap <= coarse_reg[CDLY-1];
            result_reg.overlap        <= coarse_reg[CDLY-1] &&
                                         (zero_reg[LANE_STAGES-1] || !(|sep));
        end
    end

    assign result = result_reg;

endmodule

// ===== sim/oriented_rect_overlap_test_top_tb.sv =====
// Testbench for oriented_rect_overlap_test_top: drives rectangle pairs, predicts
// overlap and coarse_overlap with its own CORDIC and separating-axis model.
// Depends on orot_pkg and the RTL of the block.
module oriented_rect_overlap_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orot_pkg::*;

    class overlap_scoreboard;
        result_t verdicts[$];
        int      mismatches;
        int      checked;
        int      stray;

        function automatic longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint trig_clamp(longint v);
            if (v > TRIG_ONE) return TRIG_ONE;
            if (v < -TRIG_ONE) return -TRIG_ONE;
            return v;
        endfunction

        function automatic longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function automatic void cos_sin(angle_t ang, output longint co, output longint si);
            logic [31:0] turn;
            logic [1:0]  quad;
            longint      z, x, y, dx, dy, c, s;
            turn = {ang, 16'h0};
            quad = turn[31:30];
            z = longint'(turn[29:0]);
            x = CORDIC_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_turn(i));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_turn(i));
                end
            end
            c = trig_clamp(floor_shift(x + ROUND_BIAS, ROUND_SHIFT));
            s = trig_clamp(floor_shift(y + ROUND_BIAS, ROUND_SHIFT));
            case (quad)
                2'd0: begin co = c;  si = s;  end
                2'd1: begin co = -s; si = c;  end
                2'd2: begin co = -c; si = -s; end
                default: begin co = s; si = -c; end
            endcase
        endfunction

        // returns 1 when the projections on axis (ux,uy) strictly overlap
        function automatic bit axis_overlaps(longint acx, longint acy, longint aw, longint ah,
                                             longint ac, longint as_, longint bcx, longint bcy,
                                             longint bw, longint bh, longint bc, longint bs,
                                             longint ux, longint uy);
            longint pa, ra, pb, rb;
            pa = acx * TRIG_ONE * ux + acy * TRIG_ONE * uy;
            ra = mag(aw * (ac * ux + as_ * uy)) + mag(ah * (ac * uy - as_ * ux));
            pb = bcx * TRIG_ONE * ux + bcy * TRIG_ONE * uy;
            rb = mag(bw * (bc * ux + bs * uy)) + mag(bh * (bc * uy - bs * ux));
            return !((pa - ra >= pb + rb) || (pb - rb >= pa + ra));
        endfunction

        function automatic result_t predict(pair_t p);
            longint  acx, acy, aw, ah, ac, as_, bcx, bcy, bw, bh, bc, bs;
            longint  aax, aay, bax, bay;
            result_t r;
            acx = longint'(p.a_center_x); acy = longint'(p.a_center_y);
            bcx = longint'(p.b_center_x); bcy = longint'(p.b_center_y);
            aw = longint'(p.a_half_width); ah = longint'(p.a_half_height);
            bw = longint'(p.b_half_width); bh = longint'(p.b_half_height);
            cos_sin(p.a_angle, ac, as_);
            cos_sin(p.b_angle, bc, bs);
            aax = mag(ac) * aw + mag(as_) * ah;
            aay = mag(as_) * aw + mag(ac) * ah;
            bax = mag(bc) * bw + mag(bs) * bh;
            bay = mag(bs) * bw + mag(bc) * bh;
            acx *= TRIG_ONE; acy *= TRIG_ONE; bcx *= TRIG_ONE; bcy *= TRIG_ONE;
            r.coarse_overlap = !((acx + aax < bcx - bax) || (bcx + bax < acx - aax) ||
                                 (acy + aay < bcy - bay) || (bcy + bay < acy - aay));
            acx /= TRIG_ONE; acy /= TRIG_ONE; bcx /= TRIG_ONE; bcy /= TRIG_ONE;
            if (!r.coarse_overlap)
                r.overlap = 1'b0;
            else if (p.a_angle == 0 && p.b_angle == 0)
                r.overlap = 1'b1;
            else
                r.overlap =
                    axis_overlaps(acx, acy, aw, ah, ac, as_, bcx, bcy, bw, bh, bc, bs, ac, as_) &&
                    axis_overlaps(acx, acy, aw, ah, ac, as_, bcx, bcy, bw, bh, bc, bs, -as_, ac) &&
                    axis_overlaps(acx, acy, aw, ah, ac, as_, bcx, bcy, bw, bh, bc, bs, bc, bs) &&
                    axis_overlaps(acx, acy, aw, ah, ac, as_, bcx, bcy, bw, bh, bc, bs, -bs, bc);
            return r;
        endfunction

        function void note_request(pair_t p);
            verdicts.push_back(predict(p));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (verdicts.size() == 0) begin
                stray++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %b", got);
                return;
            end
            want = verdicts.pop_front();
            checked++;
            if (want.overlap != got.overlap || want.coarse_overlap != got.coarse_overlap) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: overlap exp %b got %b, coarse exp %b got %b",
                             checked, want.overlap, got.overlap,
                             want.coarse_overlap, got.coarse_overlap);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    pair_valid;
    logic    pair_stall;
    pair_t   pair;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    overlap_scoreboard board;
    bit  calm;          // no idling in the last part of the run
    bit  hold_off;      // long receiver hold-off
    int  sent;
    int  coarse_hits;
    int  overlap_hits;

    oriented_rect_overlap_test_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("oriented_rect_overlap_test_top_tb: done, errors");
        $finish;
    end

    // offer one request and hold it until accepted, with random gaps before it
    task automatic send_pair(pair_t p);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            pair_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair <= p;
        pair_valid <= 1'b1;
        do @(posedge clk); while (pair_stall);
        board.note_request(p);
        sent++;
        @(negedge clk);
    endtask

    function automatic angle_t pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return angle_t'($urandom_range(0, 3) << 14);
            2: return angle_t'($urandom_range(0, 7) << 13);
            default: return angle_t'($urandom);
        endcase
    endfunction

    function automatic len_t pick_len(int span);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return len_t'($urandom);
            default: return len_t'($urandom_range(0, span));
        endcase
    endfunction

    // mostly nearby pairs so the fine test matters; some far or wide ones
    function automatic pair_t random_pair();
        pair_t p;
        int    span;
        span = ($urandom_range(0, 3) == 0) ? 1048575 : 20000;
        p.a_center_x = coord_t'($urandom);
        p.a_center_y = coord_t'($urandom);
        p.a_half_width  = pick_len(span);
        p.a_half_height = pick_len(span);
        p.a_angle = pick_angle();
        p.b_half_width  = pick_len(span);
        p.b_half_height = pick_len(span);
        p.b_angle = ($urandom_range(0, 4) == 0) ? p.a_angle : pick_angle();
        if ($urandom_range(0, 9) < 8) begin
            p.b_center_x = p.a_center_x + coord_t'($signed($urandom_range(0, 4 * span)) - 2 * span);
            p.b_center_y = p.a_center_y + coord_t'($signed($urandom_range(0, 4 * span)) - 2 * span);
        end else begin
            p.b_center_x = coord_t'($urandom);
            p.b_center_y = coord_t'($urandom);
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int aw, int ah, int aa,
                                        int bx, int by, int bw, int bh, int ba);
        pair_t p;
        p.a_center_x = coord_t'(ax); p.a_center_y = coord_t'(ay);
        p.a_half_width = len_t'(aw); p.a_half_height = len_t'(ah);
        p.a_angle = angle_t'(aa);
        p.b_center_x = coord_t'(bx); p.b_center_y = coord_t'(by);
        p.b_half_width = len_t'(bw); p.b_half_height = len_t'(bh);
        p.b_angle = angle_t'(ba);
        return p;
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                result_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
                result_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                burst = $urandom_range(1, 9);
                result_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            board.check_result(result);
            coarse_hits  += result.coarse_overlap;
            overlap_hits += result.overlap;
        end
    end

    initial begin
        int lim;
        board = new();
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        sent = 0;
        coarse_hits = 0;
        overlap_hits = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, touching, zero sizes, quadrants
        send_pair(make_pair(0, 0, 256, 256, 0, 512, 0, 256, 256, 0));         // touching, unrotated
        send_pair(make_pair(0, 0, 256, 256, 16'h2000, 512, 0, 256, 256, 0));  // rotated near
        send_pair(make_pair(0, 0, 256, 256, 16'h4000, 512, 0, 256, 256, 16'h4000)); // touch, rotated
        send_pair(make_pair(0, 0, 256, 256, 0, 513, 0, 256, 256, 0));         // just apart
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                   // two points
        send_pair(make_pair(0, 0, 0, 0, 16'h1000, 0, 0, 0, 0, 0));            // points, rotated
        send_pair(make_pair(0, 0, 1000, 0, 16'h2000, 0, 0, 0, 1000, 16'h6000)); // segments
        send_pair(make_pair(-8388608, -8388608, 1048575, 1048575, 16'hFFFF,
                            8388607, 8388607, 1048575, 1048575, 16'hFFFF));
        send_pair(make_pair(8388607, -8388608, 1048575, 0, 16'h8000,
                            8388607, -8388608, 0, 1048575, 16'hC000));
        send_pair(make_pair(-8388608, 8388607, 1048575, 1048575, 0,
                            8388607, -8388608, 1048575, 1048575, 0));
        send_pair(make_pair(0, 0, 1048575, 1048575, 16'h2000,
                            0, 0, 1048575, 1048575, 16'hA000));
        // coarse passes, fine fails: diamonds near corners; then quadrant sweeps and vertical near-touching pairs
        send_pair(make_pair(0, 0, 1000, 1000, 16'h2000, 2500, 2500, 1000, 1000, 16'h2000));
        send_pair(make_pair(0, 0, 1000, 100, 16'h1555, 1200, 1200, 1000, 100, 16'hE000));
        for (int q = 0; q < 4; q++)
            send_pair(make_pair(100, -100, 3000, 700, q << 14, 900, 400, 500, 2000, 16'h5555));
        send_pair(make_pair(0, 0, 256, 256, 16'h0001, 0, 512, 256, 256, 16'h0001));
        send_pair(make_pair(0, 0, 256, 256, 0, 0, -512, 256, 256, 16'h0000));

        // random, with one long receiver hold-off while offers continue
        for (int n = 0; n < 1130; n++) begin
            if (n == 300) hold_off = 1'b1;
            if (n == 950) calm = 1'b1;
            send_pair(random_pair());
        end
        pair_valid <= 1'b0;

        lim = 0;
        while (board.verdicts.size() != 0 && lim < 100000) begin
            @(negedge clk);
            lim++;
        end
        repeat (PIPE_STAGES + 10) @(negedge clk);

        $display("%0d pairs sent, %0d results checked: %0d coarse hits, %0d overlaps",
                 sent, board.checked, coarse_hits, overlap_hits);
        if (board.mismatches == 0 && board.verdicts.size() == 0)
            $display("oriented_rect_overlap_test_top_tb: done, clean");
        else begin
            $display("%0d mismatches, %0d results still missing",
                     board.mismatches, board.verdicts.size());
            $display("oriented_rect_overlap_test_top_tb: done, errors");
        end
        $finish;
    end

endmodule
